// File: rtl/pet_pkg.sv
package pet_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 10;
  localparam int ADDR_W  = 9;
  localparam int FILL_W  = 10;
  localparam int WIDTH_W = 10;
  localparam int HGT_W   = 11;
  localparam int THR_W   = 8;
  localparam int CFG_W   = 11;
  localparam int SUM_W   = 11;

  localparam logic [WIDTH_W-1:0] WIDTH_MIN  = 10'd3;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX  = 10'd512;
  localparam logic [HGT_W-1:0]   HGT_MIN    = 11'd3;
  localparam logic [HGT_W-1:0]   HGT_MAX    = 11'd1024;
  localparam logic [WIDTH_W-1:0] WIDTH_RST  = 10'd500;
  localparam logic [HGT_W-1:0]   HGT_RST    = 11'd600;
  localparam logic [THR_W-1:0]   THR_RST    = 8'd10;
  localparam logic [PIX_W-1:0]   MID_LEVEL  = 8'd128;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

// File: rtl/pet_if.sv
interface pet_in_if
  import pet_pkg::*;
();
  logic valid;
  logic ready;
  pix_t pixel_value;
  logic frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface pet_out_if
  import pet_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  pix_t             horiz_response;
  pix_t             vert_response;
  pix_t             gradient_byte;
  pix_t             edge_magnitude;
  logic             frame_done;

  modport source (
    output valid, output out_row, output out_col, output horiz_response,
    output vert_response, output gradient_byte, output edge_magnitude,
    output frame_done, input ready
  );
  modport sink (
    input valid, input out_row, input out_col, input horiz_response,
    input vert_response, input gradient_byte, input edge_magnitude,
    input frame_done, output ready
  );
endinterface

// File: rtl/prewitt_edge_threshold_3x3_unit.sv
// Prewitt 3x3 edge unit with magnitude threshold.
// in_pix carries grey pixels in raster order, one beat per pixel; frame_start
// on a beat puts that pixel at row 0, column 0. out_res carries one beat for
// each interior pixel once the pixel below-right of it has arrived; border
// pixels give no beat. Registers are to be written through cfg_we/cfg_index/
// cfg_wdata only while the stream is idle; the block does not enforce this.
// Writes apply from the next pixel. Throughput: one pixel per clock cycle
// while out_res is not stalled, set by the single line-store RAM port pair
// (one read, one write per cycle, with write-to-read bypass). A result goes
// through the pixel and line-store read register, then the result register.
// Reset: sizes return to 500 x 600, threshold to 10, position to row 0,
// column 0. Line-store entries read as zero until first written, tracked by
// a fill count, so there is no clearing pass and in_pix is ready at once.
// Receiver stall: the result register holds; a pixel in the stage behind it
// holds and in_pix.ready drops until the result is taken. A pixel that gives
// no result moves on whenever the result register is free or being emptied.
module prewitt_edge_threshold_3x3_unit
  import pet_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  pet_in_if.sink             in_pix,
  pet_out_if.source          out_res,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  logic [WIDTH_W-1:0] width_r;
  logic [HGT_W-1:0]   height_r;
  logic [THR_W-1:0]   thr_r;

  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [FILL_W-1:0]  fill_r;

  logic               s1_v_r;
  pix_t               s1_pix_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [COL_W-1:0]   s1_col_r;
  logic               s1_emit_r;
  logic               s1_last_r;

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_q_r;
  logic               mem_ok_r;
  logic               byp_r;
  logic [2*PIX_W-1:0] byp_d_r;

  pix_t               win_r [6];

  logic               out_v_r;
  logic [ROW_W-1:0]   o_row_r;
  logic [COL_W-1:0]   o_col_r;
  pix_t               o_hn_r, o_vn_r, o_g_r, o_mag_r;
  logic               o_done_r;

  logic               accept, s1_adv;
  logic [WIDTH_W-1:0] w_eff;
  logic [HGT_W-1:0]   h_eff;
  logic [ROW_W-1:0]   row_cur;
  logic [COL_W-1:0]   col_cur;
  logic               line_end, frame_end;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [2*PIX_W-1:0] wr_data, rd_word;
  pix_t               top, mid;
  logic signed [SUM_W-1:0] hs, vs;
  pix_t               hn, vn, g, mag, mag_thr;

  function automatic logic signed [SUM_W-1:0] ext(input pix_t p);
    ext = $signed({{(SUM_W-PIX_W){1'b0}}, p});
  endfunction

  function automatic pix_t scale_sum(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    q = (s < 0) ? ((s + 11'sd7) >>> 3) : (s >>> 3);
    scale_sum = q[PIX_W-1:0] + MID_LEVEL;
  endfunction

  assign s1_adv = s1_v_r && (!out_v_r || out_res.ready);
  assign in_pix.ready = !s1_v_r || s1_adv;
  assign accept = in_pix.valid && in_pix.ready;

  always_comb begin
    w_eff = width_r;
    if (width_r < WIDTH_MIN) w_eff = WIDTH_MIN;
    else if (width_r > WIDTH_MAX) w_eff = WIDTH_MAX;
    h_eff = height_r;
    if (height_r < HGT_MIN) h_eff = HGT_MIN;
    else if (height_r > HGT_MAX) h_eff = HGT_MAX;
  end

  always_comb begin
    row_cur   = in_pix.frame_start ? '0 : row_r;
    col_cur   = in_pix.frame_start ? '0 : col_r;
    line_end  = ({1'b0, col_cur} + 10'd1) >= w_eff;
    frame_end = ({1'b0, row_cur} + 11'd1) >= h_eff;
    col_nxt   = line_end ? '0 : col_cur + 9'd1;
    row_nxt   = row_cur;
    if (line_end) row_nxt = frame_end ? '0 : row_cur + 10'd1;
  end

  assign rd_addr = col_cur[ADDR_W-1:0];
  assign wr_addr = s1_col_r[ADDR_W-1:0];

  always_comb begin
    rd_word = mem_ok_r ? mem_q_r : '0;
    if (byp_r) rd_word = byp_d_r;
    top = rd_word[2*PIX_W-1:PIX_W];
    mid = rd_word[PIX_W-1:0];
    wr_data = {mid, s1_pix_r};
  end

  always_ff @(posedge clk) begin
    if (s1_adv) mem[wr_addr] <= wr_data;
    if (accept) mem_q_r <= mem[rd_addr];
  end

  always_comb begin
    hs = (ext(win_r[2]) + ext(win_r[5]) + ext(s1_pix_r))
       - (ext(win_r[0]) + ext(win_r[3]) + ext(top));
    vs = (ext(top) + ext(mid) + ext(s1_pix_r))
       - (ext(win_r[0]) + ext(win_r[1]) + ext(win_r[2]));
    hn = scale_sum(hs);
    vn = scale_sum(vs);
    g  = hn - vn + MID_LEVEL;
    mag = (g >= MID_LEVEL) ? g - MID_LEVEL : MID_LEVEL - g;
    mag_thr = (mag < thr_r) ? '0 : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HGT_RST;
      thr_r    <= THR_RST;
      row_r    <= '0;
      col_r    <= '0;
      fill_r   <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:    width_r  <= cfg_wdata[WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT:   height_r <= cfg_wdata[HGT_W-1:0];
          CFG_EDGE_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (s1_adv && ({1'b0, wr_addr} >= fill_r)) fill_r <= {1'b0, wr_addr} + 10'd1;
      if (accept) s1_v_r <= 1'b1;
      else if (s1_adv) s1_v_r <= 1'b0;
      if (out_res.ready) out_v_r <= 1'b0;
      if (s1_adv && s1_emit_r) out_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_pix.pixel_value;
      s1_row_r  <= row_cur;
      s1_col_r  <= col_cur;
      s1_emit_r <= (row_cur >= 10'd2) && (col_cur >= 9'd2);
      s1_last_r <= frame_end && line_end;
      mem_ok_r  <= {1'b0, rd_addr} < fill_r;
      byp_r     <= s1_adv && (wr_addr == rd_addr);
      byp_d_r   <= wr_data;
    end
    if (s1_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1_pix_r;
    end
    if (s1_adv && s1_emit_r) begin
      o_row_r  <= s1_row_r - 10'd1;
      o_col_r  <= s1_col_r - 9'd1;
      o_hn_r   <= hn;
      o_vn_r   <= vn;
      o_g_r    <= g;
      o_mag_r  <= mag_thr;
      o_done_r <= s1_last_r;
    end
  end

  assign out_res.valid          = out_v_r;
  assign out_res.out_row        = o_row_r;
  assign out_res.out_col        = o_col_r;
  assign out_res.horiz_response = o_hn_r;
  assign out_res.vert_response  = o_vn_r;
  assign out_res.gradient_byte  = o_g_r;
  assign out_res.edge_magnitude = o_mag_r;
  assign out_res.frame_done     = o_done_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_WIDTH))
    else $error("line-store fill count beyond depth");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_res.ready |=> s1_v_r && $stable(s1_col_r))
    else $error("pixel stage lost while result stalled");

  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (o_row_r != '0) && (o_col_r != '0))
    else $error("border pixel emitted");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |-> !in_pix.ready)
    else $error("pixel accepted over a held stage");
`endif

endmodule

// File: verif/tb_prewitt_edge_threshold_3x3_unit.sv
module tb_prewitt_edge_threshold_3x3_unit
  import pet_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pix_t             horiz;
    pix_t             vert;
    pix_t             grad;
    pix_t             mag;
    logic             done;
  } edge_result_t;

  typedef struct packed {
    pix_t pix;
    logic fs;
  } pixel_beat_t;

  typedef enum int {
    PAT_NOISE,
    PAT_SMOOTH,
    PAT_EXTREME
  } pix_pattern_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  pet_in_if  pix_if ();
  pet_out_if res_if ();

  prewitt_edge_threshold_3x3_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_if),
    .out_res   (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  logic [WIDTH_W-1:0] cur_width;
  logic [HGT_W-1:0]   cur_height;
  pix_t               cur_thr;
  pix_t               upper_line  [MAX_WIDTH];
  pix_t               middle_line [MAX_WIDTH];
  pix_t               window_px   [6];
  int unsigned        row_pos;
  int unsigned        col_pos;

  pixel_beat_t  pixel_backlog [$];
  edge_result_t pending_edges [$];
  pixel_beat_t  held_beat;

  int unsigned error_count   = 0;
  int unsigned pixels_sent   = 0;
  int unsigned edges_checked = 0;
  int unsigned settings_run  = 0;
  int unsigned in_gap        = 0;
  int unsigned out_gap       = 0;
  int unsigned idle_cycles   = 0;
  bit          quiet         = 1'b0;

  initial begin
    pix_if.valid       = 1'b0;
    pix_if.pixel_value = '0;
    pix_if.frame_start = 1'b0;
    res_if.ready       = 1'b0;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pix_t offset_eighth(int signed s);
    return pix_t'(s / 8 + 128);
  endfunction

  function automatic void clear_prewitt_state();
    cur_width  = WIDTH_RST;
    cur_height = HGT_RST;
    cur_thr    = THR_RST;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) window_px[i] = '0;
    row_pos = 0;
    col_pos = 0;
  endfunction

  function automatic void apply_prewitt(pixel_beat_t b);
    int unsigned  w;
    int unsigned  h;
    int unsigned  row;
    int unsigned  col;
    int unsigned  idx;
    int signed    hs;
    int signed    vs;
    pix_t         top;
    pix_t         mid;
    pix_t         hn;
    pix_t         vn;
    pix_t         g;
    pix_t         m;
    edge_result_t r;
    w = clamp_size(cur_width, 3, MAX_WIDTH);
    h = clamp_size(cur_height, 3, MAX_HEIGHT);
    if (b.fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    row = row_pos;
    col = col_pos;
    idx = col % MAX_WIDTH;
    top = upper_line[idx];
    mid = middle_line[idx];
    if (row >= 2 && col >= 2) begin
      hs = (int'(window_px[2]) + int'(window_px[5]) + int'(b.pix))
         - (int'(window_px[0]) + int'(window_px[3]) + int'(top));
      vs = (int'(top) + int'(mid) + int'(b.pix))
         - (int'(window_px[0]) + int'(window_px[1]) + int'(window_px[2]));
      hn = offset_eighth(hs);
      vn = offset_eighth(vs);
      g  = hn - vn + MID_LEVEL;
      m  = (g >= MID_LEVEL) ? g - MID_LEVEL : MID_LEVEL - g;
      if (m < cur_thr) m = '0;
      r.row   = ROW_W'(row - 1);
      r.col   = COL_W'(col - 1);
      r.horiz = hn;
      r.vert  = vn;
      r.grad  = g;
      r.mag   = m;
      r.done  = (row + 1 >= h) && (col + 1 >= w);
      pending_edges.push_back(r);
    end
    window_px[0] = window_px[3];
    window_px[1] = window_px[4];
    window_px[2] = window_px[5];
    window_px[3] = top;
    window_px[4] = mid;
    window_px[5] = b.pix;
    upper_line[idx]  = mid;
    middle_line[idx] = b.pix;
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
  endfunction

  function automatic void log_error(string msg);
    if (error_count < 10) $display("%s", msg);
    error_count++;
  endfunction

  function automatic void queue_pixel(pix_t pix, logic fs);
    pixel_beat_t b;
    b.pix = pix;
    b.fs  = fs;
    pixel_backlog.push_back(b);
  endfunction

  function automatic pix_t next_pixel(pix_pattern_t pat, pix_t last);
    int v;
    case (pat)
      PAT_SMOOTH: begin
        v = int'(last) + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return pix_t'(v);
      end
      PAT_EXTREME: begin
        return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      end
      default: begin
        return pix_t'($urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || pix_if.valid || pending_edges.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_IMAGE_WIDTH:    cur_width  = val[WIDTH_W-1:0];
      CFG_IMAGE_HEIGHT:   cur_height = val[HGT_W-1:0];
      CFG_EDGE_THRESHOLD: cur_thr    = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned w, input int unsigned h,
                           input int unsigned thr);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
    write_reg(CFG_EDGE_THRESHOLD, CFG_W'(thr));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  task automatic queue_frames(input int unsigned n_items);
    int unsigned  w;
    int unsigned  h;
    int unsigned  frame_len;
    int unsigned  cut;
    int unsigned  pos;
    int unsigned  k;
    bit           clean;
    pix_pattern_t pat;
    pix_t         last;
    logic         fs;
    w         = clamp_size(cur_width, 3, MAX_WIDTH);
    h         = clamp_size(cur_height, 3, MAX_HEIGHT);
    frame_len = w * h;
    clean     = (frame_len >= 1000);
    k         = 0;
    last      = '0;
    while (k < n_items) begin
      pat = pix_pattern_t'($urandom_range(0, 2));
      cut = frame_len;
      if (!clean && $urandom_range(0, 7) == 0) cut = $urandom_range(1, frame_len);
      for (pos = 0; pos < cut && k < n_items; pos++) begin
        if (pos == 0) fs = ($urandom_range(0, 5) != 0);
        else          fs = !clean && ($urandom_range(0, 199) == 0);
        last = next_pixel(pat, last);
        queue_pixel(last, fs);
        k++;
      end
    end
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h,
                           input int unsigned thr, input int unsigned n_items);
    configure(w, h, thr);
    queue_frames(n_items);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pix_if.valid       <= 1'b0;
      pix_if.pixel_value <= '0;
      pix_if.frame_start <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        apply_prewitt(held_beat);
        pixels_sent++;
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (in_gap != 0) begin
          in_gap--;
          pix_if.valid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          held_beat = pixel_backlog.pop_front();
          pix_if.valid       <= 1'b1;
          pix_if.pixel_value <= held_beat.pix;
          pix_if.frame_start <= held_beat.fs;
          if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 16);
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    edge_result_t got;
    edge_result_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.row   = res_if.out_row;
        got.col   = res_if.out_col;
        got.horiz = res_if.horiz_response;
        got.vert  = res_if.vert_response;
        got.grad  = res_if.gradient_byte;
        got.mag   = res_if.edge_magnitude;
        got.done  = res_if.frame_done;
        if (pending_edges.size() == 0) begin
          log_error($sformatf("unexpected result beat: row %0d col %0d", got.row, got.col));
        end else begin
          want = pending_edges.pop_front();
          edges_checked++;
          if (got.row !== want.row || got.col !== want.col || got.horiz !== want.horiz ||
              got.vert !== want.vert || got.grad !== want.grad || got.mag !== want.mag ||
              got.done !== want.done) begin
            log_error({
              $sformatf("mismatch: exp row %0d col %0d h %0d v %0d g %0d mag %0d done %0b",
                        want.row, want.col, want.horiz, want.vert, want.grad, want.mag,
                        want.done),
              $sformatf(" / got row %0d col %0d h %0d v %0d g %0d mag %0d done %0b",
                        got.row, got.col, got.horiz, got.vert, got.grad, got.mag,
                        got.done)});
          end
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 16);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_edges.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    clear_prewitt_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    configure(3, 3, 0);
    // strongest positive and negative gradients, then a frame that wraps by itself
    queue_pixel(8'd0,   1'b1); queue_pixel(8'd0,   1'b0); queue_pixel(8'd0,   1'b0);
    queue_pixel(8'd255, 1'b0); queue_pixel(8'd128, 1'b0); queue_pixel(8'd0,   1'b0);
    queue_pixel(8'd255, 1'b0); queue_pixel(8'd255, 1'b0); queue_pixel(8'd0,   1'b0);
    queue_pixel(8'd0,   1'b0); queue_pixel(8'd255, 1'b0); queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd0,   1'b0); queue_pixel(8'd128, 1'b0); queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd0,   1'b0); queue_pixel(8'd0,   1'b0); queue_pixel(8'd0,   1'b0);
    // cut a frame short with a new frame start
    queue_pixel(8'd200, 1'b0); queue_pixel(8'd17,  1'b0);
    queue_pixel(8'd255, 1'b1); queue_pixel(8'd255, 1'b0); queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd60,  1'b0); queue_pixel(8'd70,  1'b0); queue_pixel(8'd80,  1'b0);
    queue_pixel(8'd0,   1'b0); queue_pixel(8'd0,   1'b0); queue_pixel(8'd0,   1'b0);

    run_phase(5, 4, 10, 80);
    run_phase(0, 2, 255, 50);
    // width 1029 keeps only its low ten bits
    run_phase(1029, 6, 128, 60);
    run_phase(1023, 3, 40, 1540);
    run_phase(3, 2047, 20, 60);
    run_phase(20, 10, 5, 100);
    // shrink while mid-frame: line and frame end early
    run_phase(4, 5, 1, 60);
    run_phase(2, 1, 0, 30);
    run_phase(512, 1024, 30, 40);
    for (int i = 0; i < 3; i++) begin
      run_phase($urandom_range(3, 24), $urandom_range(3, 16), $urandom_range(0, 70),
                $urandom_range(20, 50));
    end
    quiet = 1'b1;
    run_phase($urandom_range(3, 12), $urandom_range(3, 8), $urandom_range(0, 40), 60);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_edges.size() != 0)
      log_error($sformatf("%0d results never arrived", pending_edges.size()));
    $display("run covered %0d pixel beats and %0d checked edge results over %0d settings",
             pixels_sent, edges_checked, settings_run);
    $display("sizes from 3x3 up to 512 wide, clamped and truncated sizes, thresholds 0 to 255");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: prewitt_edge_threshold_3x3_unit.f
rtl/pet_pkg.sv
rtl/pet_if.sv
rtl/prewitt_edge_threshold_3x3_unit.sv
verif/tb_prewitt_edge_threshold_3x3_unit.sv
